>>> hdl/mrfd_pkg.sv
package mrfd_pkg;

  typedef logic [5:0] node_t;

  typedef enum logic [2:0] {
    ST_UPDATED    = 3'd0,
    ST_ECHO       = 3'd1,
    ST_BAD_OPCODE = 3'd2,
    ST_BAD_NODE   = 3'd3,
    ST_READ_DONE  = 3'd4
  } status_t;

  // operation codes of an input beat
  localparam logic OP_DECODE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // configuration register indexes
  localparam logic [2:0] CFG_MOTOR_COUNT = 3'd0;
  localparam logic [2:0] CFG_NODE_ID_0   = 3'd1;

  localparam logic [5:0] NODE_MASK = 6'h3f;

  // reply opcodes, first payload byte
  localparam logic [7:0] OPC_STATUS1  = 8'h9A;
  localparam logic [7:0] OPC_MOTION   = 8'h9C;
  localparam logic [7:0] OPC_TORQUE   = 8'hA1;
  localparam logic [7:0] OPC_SPEED    = 8'hA2;
  localparam logic [7:0] OPC_POS_A3   = 8'hA3;
  localparam logic [7:0] OPC_POS_A4   = 8'hA4;
  localparam logic [7:0] OPC_POS_A5   = 8'hA5;
  localparam logic [7:0] OPC_POS_A6   = 8'hA6;
  localparam logic [7:0] OPC_PHASE    = 8'h9D;
  localparam logic [7:0] OPC_ANGLE    = 8'h94;
  localparam logic [7:0] OPC_MULTI    = 8'h92;
  localparam logic [7:0] OPC_ENCODER  = 8'h90;
  localparam logic [7:0] OPC_GAINS    = 8'h30;
  localparam logic [7:0] OPC_ACCEL    = 8'h33;

  // telemetry field codes for reads
  localparam logic [3:0] FLD_TEMP    = 4'd0;
  localparam logic [3:0] FLD_VOLT    = 4'd1;
  localparam logic [3:0] FLD_ERR     = 4'd2;
  localparam logic [3:0] FLD_TORQUE  = 4'd3;
  localparam logic [3:0] FLD_SPEED   = 4'd4;
  localparam logic [3:0] FLD_POS     = 4'd5;
  localparam logic [3:0] FLD_PHASE_A = 4'd6;
  localparam logic [3:0] FLD_PHASE_B = 4'd7;
  localparam logic [3:0] FLD_PHASE_C = 4'd8;
  localparam logic [3:0] FLD_MULTI   = 4'd9;
  localparam logic [3:0] FLD_RAW     = 4'd10;
  localparam logic [3:0] FLD_OFFSET  = 4'd11;
  localparam logic [3:0] FLD_GAINS   = 4'd12;
  localparam logic [3:0] FLD_ACCEL   = 4'd13;

  // store write strobes from the frame decoder
  typedef struct packed {
    logic status1;
    logic motion;
    logic angle;
    logic encoder;
    logic phase;
    logic multi;
    logic gains;
    logic accel;
  } wr_t;

endpackage

>>> hdl/mrfd_slot_match.sv
module mrfd_slot_match #(
  parameter int MOTORS = 4
) (
  input  logic [MOTORS-1:0][5:0] node_ids,
  input  logic [2:0]             motor_count,
  input  mrfd_pkg::node_t        node,
  output logic                   hit,
  output logic [1:0]             slot
);
  import mrfd_pkg::*;

  // lowest matching slot wins, so scan from the top down
  always_comb begin
    hit  = 1'b0;
    slot = 2'd0;
    for (int i = MOTORS - 1; i >= 0; i--) begin
      if (motor_count > 3'(i) && node_ids[i] == node) begin
        hit  = 1'b1;
        slot = 2'(i);
      end
    end
  end

endmodule

>>> hdl/mrfd_frame_decode.sv
module mrfd_frame_decode (
  input  logic              en,
  input  logic              hit,
  input  logic [63:0]       data,
  output mrfd_pkg::wr_t     wr,
  output mrfd_pkg::status_t status,
  output logic              fault
);
  import mrfd_pkg::*;

  logic [7:0] opc;
  logic [7:0] b1;

  assign opc = data[7:0];
  assign b1  = data[15:8];

  always_comb begin
    wr     = '0;
    status = ST_UPDATED;
    fault  = 1'b0;
    if (!hit) begin
      status = ST_BAD_NODE;
    end else begin
      case (opc)
        OPC_STATUS1: begin
          wr.status1 = 1'b1;
          fault      = data[63:56] != 8'd0;
        end
        OPC_MOTION, OPC_TORQUE, OPC_SPEED, OPC_POS_A3, OPC_POS_A4: begin
          // zero in byte 1 marks an echoed request
          if (b1 != 8'd0) wr.motion = 1'b1;
          else status = ST_ECHO;
        end
        OPC_POS_A5, OPC_POS_A6: begin
          if (b1 > 8'd1) wr.motion = 1'b1;
          else status = ST_ECHO;
        end
        OPC_PHASE: begin
          if (data[63:48] != 16'd0) wr.phase = 1'b1;
          else status = ST_ECHO;
        end
        OPC_ANGLE:   wr.angle   = 1'b1;
        OPC_MULTI:   wr.multi   = 1'b1;
        OPC_ENCODER: wr.encoder = 1'b1;
        OPC_GAINS:   wr.gains   = 1'b1;
        OPC_ACCEL:   wr.accel   = 1'b1;
        default:     status     = ST_BAD_OPCODE;
      endcase
    end
    if (!en) begin
      wr = '0;
    end
  end

endmodule

>>> hdl/mrfd_telemetry.sv
module mrfd_telemetry #(
  parameter int MOTORS = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mrfd_pkg::wr_t wr,
  input  logic [1:0]    wr_slot,
  input  logic [63:0]   wr_data,
  input  logic [1:0]    rd_slot,
  input  logic [3:0]    rd_field,
  output logic [47:0]   rd_data
);
  import mrfd_pkg::*;

  logic [7:0]  temp_r   [MOTORS];
  logic [15:0] volt_r   [MOTORS];
  logic [7:0]  err_r    [MOTORS];
  logic [15:0] torque_r [MOTORS];
  logic [15:0] speed_r  [MOTORS];
  logic [15:0] pos_r    [MOTORS];
  logic [47:0] phase_r  [MOTORS];
  logic [55:0] multi_r  [MOTORS];
  logic [31:0] enc_r    [MOTORS];
  logic [47:0] gains_r  [MOTORS];
  logic [31:0] accel_r  [MOTORS];

  always_ff @(posedge clk) begin
    for (int i = 0; i < MOTORS; i++) begin
      if (!rst_n) begin
        temp_r[i]   <= '0;
        volt_r[i]   <= '0;
        err_r[i]    <= '0;
        torque_r[i] <= '0;
        speed_r[i]  <= '0;
        pos_r[i]    <= '0;
        phase_r[i]  <= '0;
        multi_r[i]  <= '0;
        enc_r[i]    <= '0;
        gains_r[i]  <= '0;
        accel_r[i]  <= '0;
      end else if (wr_slot == 2'(i)) begin
        if (wr.status1) begin
          temp_r[i] <= wr_data[15:8];
          volt_r[i] <= wr_data[39:24];
          err_r[i]  <= wr_data[63:56];
        end
        if (wr.motion) begin
          temp_r[i]   <= wr_data[15:8];
          torque_r[i] <= wr_data[31:16];
          speed_r[i]  <= wr_data[47:32];
          pos_r[i]    <= wr_data[63:48];
        end
        if (wr.angle) pos_r[i] <= wr_data[63:48];
        if (wr.encoder) begin
          pos_r[i] <= wr_data[31:16];
          enc_r[i] <= wr_data[63:32];
        end
        if (wr.phase) phase_r[i] <= wr_data[63:16];
        if (wr.multi) multi_r[i] <= wr_data[63:8];
        if (wr.gains) gains_r[i] <= wr_data[63:16];
        if (wr.accel) accel_r[i] <= wr_data[63:32];
      end
    end
  end

  // slots at or above MOTORS never match and read as zero
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < MOTORS; i++) begin
      if (rd_slot == 2'(i)) begin
        case (rd_field)
          FLD_TEMP:    rd_data = 48'(temp_r[i]);
          FLD_VOLT:    rd_data = 48'(volt_r[i]);
          FLD_ERR:     rd_data = 48'(err_r[i]);
          FLD_TORQUE:  rd_data = 48'(torque_r[i]);
          FLD_SPEED:   rd_data = 48'(speed_r[i]);
          FLD_POS:     rd_data = 48'(pos_r[i]);
          FLD_PHASE_A: rd_data = 48'(phase_r[i][15:0]);
          FLD_PHASE_B: rd_data = 48'(phase_r[i][31:16]);
          FLD_PHASE_C: rd_data = 48'(phase_r[i][47:32]);
          FLD_MULTI:   rd_data = multi_r[i][47:0];
          FLD_RAW:     rd_data = 48'(enc_r[i][15:0]);
          FLD_OFFSET:  rd_data = 48'(enc_r[i][31:16]);
          FLD_GAINS:   rd_data = gains_r[i];
          FLD_ACCEL:   rd_data = 48'(accel_r[i]);
          default:     rd_data = '0;
        endcase
      end
    end
  end

endmodule

>>> hdl/motor_reply_frame_decoder.sv
// channel  | handshake                | payload
// ---------+--------------------------+---------------------------------------------
// input    | start, busy (held low)   | in_operation, in_frame_id, in_frame_data,
//          |                          | in_slot_select, in_field_select
// result   | out_valid, one cycle     | out_node_number, out_status, out_slot_hit,
//          |                          | out_read_data, out_fault_flag
// config   | cfg_we                   | cfg_index, cfg_data
//
// one beat per clock; the result register loads at the edge after the accepting edge,
// so the result is on the ports during the next cycle:
// input register, then slot compare, opcode decode and field mux into the result
// register, with the telemetry store written at that same edge.
// a beat sees every store write of the beat before it.
// rst_n is synchronous; it clears the node table, the telemetry store and valids.
// no stalls: busy stays low and out_valid lasts exactly one cycle.
module motor_reply_frame_decoder #(
  parameter int MOTORS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [10:0] in_frame_id,
  input  logic [63:0] in_frame_data,
  input  logic [1:0]  in_slot_select,
  input  logic [3:0]  in_field_select,
  output logic        out_valid,
  output logic [5:0]  out_node_number,
  output logic [2:0]  out_status,
  output logic [1:0]  out_slot_hit,
  output logic [47:0] out_read_data,
  output logic        out_fault_flag,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [5:0]  cfg_data
);
  import mrfd_pkg::*;

  logic [2:0]             motor_count_r;
  logic [MOTORS-1:0][5:0] node_ids_r;

  logic        item_valid_r;
  logic        op_r;
  node_t       node_r;
  logic [63:0] data_r;
  logic [1:0]  sel_slot_r;
  logic [3:0]  sel_field_r;

  logic        hit;
  logic [1:0]  match_slot;
  logic        store_en;
  wr_t         wr;
  status_t     dec_status;
  logic        dec_fault;
  logic [47:0] rd_data;

  logic        out_valid_r,  out_valid_nxt;
  node_t       out_node_r,   out_node_nxt;
  status_t     out_status_r, out_status_nxt;
  logic [1:0]  out_slot_r,   out_slot_nxt;
  logic [47:0] out_data_r,   out_data_nxt;
  logic        out_fault_r,  out_fault_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motor_count_r <= '0;
      node_ids_r    <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MOTOR_COUNT) motor_count_r <= cfg_data[2:0];
      for (int i = 0; i < MOTORS; i++) begin
        if (cfg_index == CFG_NODE_ID_0 + 3'(i)) node_ids_r[i] <= cfg_data & NODE_MASK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r        <= in_operation;
      node_r      <= in_frame_id[5:0];
      data_r      <= in_frame_data;
      sel_slot_r  <= in_slot_select;
      sel_field_r <= in_field_select;
    end
  end

  mrfd_slot_match #(.MOTORS(MOTORS)) u_match (
    .node_ids    (node_ids_r),
    .motor_count (motor_count_r),
    .node        (node_r),
    .hit         (hit),
    .slot        (match_slot)
  );

  assign store_en = item_valid_r && op_r == OP_DECODE;

  mrfd_frame_decode u_decode (
    .en     (store_en),
    .hit    (hit),
    .data   (data_r),
    .wr     (wr),
    .status (dec_status),
    .fault  (dec_fault)
  );

  mrfd_telemetry #(.MOTORS(MOTORS)) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .wr_slot  (match_slot),
    .wr_data  (data_r),
    .rd_slot  (sel_slot_r),
    .rd_field (sel_field_r),
    .rd_data  (rd_data)
  );

  always_comb begin
    out_valid_nxt = item_valid_r;
    if (op_r == OP_READ) begin
      out_node_nxt   = '0;
      out_status_nxt = ST_READ_DONE;
      out_slot_nxt   = sel_slot_r;
      out_data_nxt   = rd_data;
      out_fault_nxt  = 1'b0;
    end else begin
      out_node_nxt   = node_r;
      out_status_nxt = dec_status;
      out_slot_nxt   = hit ? match_slot : 2'd0;
      out_data_nxt   = '0;
      out_fault_nxt  = dec_fault;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_node_r   <= out_node_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_data_r   <= out_data_nxt;
    out_fault_r  <= out_fault_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_node_number = out_node_r;
  assign out_status      = out_status_r;
  assign out_slot_hit    = out_slot_r;
  assign out_read_data   = out_data_r;
  assign out_fault_flag  = out_fault_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> ##1 out_valid)
    else $error("accepted beat produced no result");

  a_no_store_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (store_en && !hit) |-> wr == '0)
    else $error("store written for an unknown node");

  a_fault_only_updated: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fault_flag) |-> out_status == ST_UPDATED)
    else $error("fault flag on a result that stored nothing");

  a_decode_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_READ_DONE) |-> out_read_data == '0)
    else $error("decode result carries read data");

endmodule

>>> test/reply_checker.sv
`timescale 1ns / 100ps

module reply_checker #(
  parameter int MOTORS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_operation,
  input  logic [10:0] in_frame_id,
  input  logic [63:0] in_frame_data,
  input  logic [1:0]  in_slot_select,
  input  logic [3:0]  in_field_select,
  input  logic        out_valid,
  input  logic [5:0]  out_node_number,
  input  logic [2:0]  out_status,
  input  logic [1:0]  out_slot_hit,
  input  logic [47:0] out_read_data,
  input  logic        out_fault_flag,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [5:0]  cfg_data,
  output int          fail_count,
  output int          pending
);
  import mrfd_pkg::*;

  typedef struct packed {
    node_t       node;
    status_t     status;
    logic [1:0]  slot;
    logic [47:0] data;
    logic        fault;
  } reply_t;

  reply_t expected_replies[$];

  // node table as the block should hold it
  logic [2:0] motor_count_r;
  node_t      node_tab[4];

  // telemetry store, one entry per motor slot
  logic [7:0]  temp_r[MOTORS];
  logic [15:0] volt_r[MOTORS];
  logic [7:0]  err_r[MOTORS];
  logic [15:0] torque_r[MOTORS];
  logic [15:0] speed_r[MOTORS];
  logic [15:0] pos_r[MOTORS];
  logic [47:0] phase_r[MOTORS];
  logic [55:0] multi_r[MOTORS];
  logic [31:0] rawoff_r[MOTORS];
  logic [47:0] gains_r[MOTORS];
  logic [31:0] accel_r[MOTORS];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic reply_t decode_reply(logic op, logic [10:0] fid, logic [63:0] d,
                                          logic [1:0] ss, logic [3:0] fs);
    reply_t     r;
    int         count;
    logic       hit;
    logic [1:0] slot;
    logic [7:0] opc;
    logic [7:0] b1;
    node_t      node;
    r      = '0;
    hit    = 1'b0;
    slot   = '0;
    node   = fid[5:0] & NODE_MASK;
    opc    = d[7:0];
    b1     = d[15:8];
    if (op == OP_READ) begin
      r.status = ST_READ_DONE;
      r.slot   = ss;
      if (ss < MOTORS) begin
        case (fs)
          FLD_TEMP:    r.data = 48'(temp_r[ss]);
          FLD_VOLT:    r.data = 48'(volt_r[ss]);
          FLD_ERR:     r.data = 48'(err_r[ss]);
          FLD_TORQUE:  r.data = 48'(torque_r[ss]);
          FLD_SPEED:   r.data = 48'(speed_r[ss]);
          FLD_POS:     r.data = 48'(pos_r[ss]);
          FLD_PHASE_A: r.data = 48'(phase_r[ss][15:0]);
          FLD_PHASE_B: r.data = 48'(phase_r[ss][31:16]);
          FLD_PHASE_C: r.data = 48'(phase_r[ss][47:32]);
          FLD_MULTI:   r.data = multi_r[ss][47:0];
          FLD_RAW:     r.data = 48'(rawoff_r[ss][15:0]);
          FLD_OFFSET:  r.data = 48'(rawoff_r[ss][31:16]);
          FLD_GAINS:   r.data = gains_r[ss];
          FLD_ACCEL:   r.data = 48'(accel_r[ss]);
          default:     r.data = '0;
        endcase
      end
      return r;
    end

    // counts above the slot total act as the slot total
    count = (motor_count_r > MOTORS) ? MOTORS : int'(motor_count_r);
    for (int i = 0; i < 4; i++) begin
      if (!hit && i < count && node_tab[i] == node) begin
        hit  = 1'b1;
        slot = 2'(i);
      end
    end

    r.node   = node;
    r.status = ST_UPDATED;
    if (!hit) begin
      r.status = ST_BAD_NODE;
      return r;
    end
    r.slot = slot;
    case (opc)
      OPC_STATUS1: begin
        temp_r[slot] = b1;
        volt_r[slot] = d[39:24];
        err_r[slot]  = d[63:56];
        r.fault      = (d[63:56] != 8'h00);
      end
      OPC_MOTION, OPC_TORQUE, OPC_SPEED, OPC_POS_A3, OPC_POS_A4,
      OPC_POS_A5, OPC_POS_A6: begin
        // the A5/A6 echo test also drops byte 1 == 1
        if ((opc == OPC_POS_A5 || opc == OPC_POS_A6) ? (b1 > 8'd1) : (b1 != 8'd0)) begin
          temp_r[slot]   = b1;
          torque_r[slot] = d[31:16];
          speed_r[slot]  = d[47:32];
          pos_r[slot]    = d[63:48];
        end else begin
          r.status = ST_ECHO;
        end
      end
      OPC_PHASE: begin
        if (d[63:48] != 16'h0000) phase_r[slot] = d[63:16];
        else r.status = ST_ECHO;
      end
      OPC_ANGLE: pos_r[slot] = d[63:48];
      OPC_MULTI: multi_r[slot] = d[63:8];
      OPC_ENCODER: begin
        pos_r[slot]    = d[31:16];
        rawoff_r[slot] = d[63:32];
      end
      OPC_GAINS: gains_r[slot] = d[63:16];
      OPC_ACCEL: accel_r[slot] = d[63:32];
      default:   r.status = ST_BAD_OPCODE;
    endcase
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] seen);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch on %s: expected %0h, got %0h", what, want, seen);
  endtask

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (!rst_n) begin
      expected_replies.delete();
      motor_count_r = '0;
      for (int i = 0; i < 4; i++) node_tab[i] = '0;
      for (int i = 0; i < MOTORS; i++) begin
        temp_r[i] = '0;   volt_r[i] = '0;   err_r[i] = '0;
        torque_r[i] = '0; speed_r[i] = '0;  pos_r[i] = '0;
        phase_r[i] = '0;  multi_r[i] = '0;  rawoff_r[i] = '0;
        gains_r[i] = '0;  accel_r[i] = '0;
      end
    end else begin
      if (out_valid) begin
        got.node   = out_node_number;
        got.status = status_t'(out_status);
        got.slot   = out_slot_hit;
        got.data   = out_read_data;
        got.fault  = out_fault_flag;
        if (expected_replies.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result beat: status %0d node %0h", out_status,
                     out_node_number);
        end else begin
          want = expected_replies.pop_front();
          if (got.node !== want.node)
            note_mismatch("node_number", 64'(want.node), 64'(got.node));
          if (got.status !== want.status)
            note_mismatch("status", 64'(want.status), 64'(got.status));
          if (got.slot !== want.slot)
            note_mismatch("slot_hit", 64'(want.slot), 64'(got.slot));
          if (got.data !== want.data)
            note_mismatch("read_data", 64'(want.data), 64'(got.data));
          if (got.fault !== want.fault)
            note_mismatch("fault_flag", 64'(want.fault), 64'(got.fault));
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_MOTOR_COUNT)
          motor_count_r = cfg_data[2:0];
        else if (cfg_index >= CFG_NODE_ID_0 && cfg_index <= CFG_NODE_ID_0 + 3'd3)
          node_tab[cfg_index - CFG_NODE_ID_0] = cfg_data & NODE_MASK;
      end
      if (start && !busy)
        expected_replies.push_back(decode_reply(in_operation, in_frame_id, in_frame_data,
                                                in_slot_select, in_field_select));
    end
    pending = expected_replies.size();
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import mrfd_pkg::*;

  localparam int WATCHDOG_LIMIT = 500;
  // opcodes outside the reply set
  localparam logic [7:0] OPC_NONE_LO = 8'h00;
  localparam logic [7:0] OPC_NONE_HI = 8'hFF;
  localparam logic [3:0] FLD_UNUSED  = 4'd15;
  // register index with nothing behind it
  localparam logic [2:0] CFG_SPARE   = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_operation = OP_DECODE;
  logic [10:0] in_frame_id = '0;
  logic [63:0] in_frame_data = '0;
  logic [1:0]  in_slot_select = '0;
  logic [3:0]  in_field_select = '0;
  logic        out_valid;
  logic [5:0]  out_node_number;
  logic [2:0]  out_status;
  logic [1:0]  out_slot_hit;
  logic [47:0] out_read_data;
  logic        out_fault_flag;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_MOTOR_COUNT;
  logic [5:0]  cfg_data = '0;

  int    fail_count;
  int    pending;
  int    idle_cycles = 0;
  bit    no_gaps = 1'b0;
  node_t node_tab[4];

  always #4 clk = ~clk;

  motor_reply_frame_decoder #(.MOTORS(4)) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_frame_id     (in_frame_id),
    .in_frame_data   (in_frame_data),
    .in_slot_select  (in_slot_select),
    .in_field_select (in_field_select),
    .out_valid       (out_valid),
    .out_node_number (out_node_number),
    .out_status      (out_status),
    .out_slot_hit    (out_slot_hit),
    .out_read_data   (out_read_data),
    .out_fault_flag  (out_fault_flag),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  reply_checker #(.MOTORS(4)) u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_frame_id     (in_frame_id),
    .in_frame_data   (in_frame_data),
    .in_slot_select  (in_slot_select),
    .in_field_select (in_field_select),
    .out_valid       (out_valid),
    .out_node_number (out_node_number),
    .out_status      (out_status),
    .out_slot_hit    (out_slot_hit),
    .out_read_data   (out_read_data),
    .out_fault_flag  (out_fault_flag),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // any beat, result or register write counts as progress
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_beat(logic op, logic [10:0] fid, logic [63:0] d, logic [1:0] ss,
                           logic [3:0] fs);
    @(negedge clk);
    if (!no_gaps && $urandom_range(0, 99) < 20) begin
      start = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    start           = 1'b1;
    in_operation    = op;
    in_frame_id     = fid;
    in_frame_data   = d;
    in_slot_select  = ss;
    in_field_select = fs;
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  // drop start, let every expected beat come back, then give the pipe time to empty
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [5:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic load_table(logic [2:0] count);
    write_reg(CFG_MOTOR_COUNT, {3'b000, count});
    for (int i = 0; i < 4; i++) write_reg(CFG_NODE_ID_0 + 3'(i), node_tab[i]);
  endtask

  task automatic random_beat();
    logic [63:0] d;
    logic [7:0]  opc;
    node_t       node;
    d = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 35) begin
      send_beat(OP_READ, 11'($urandom), d, 2'($urandom), 4'($urandom));
    end else begin
      node = ($urandom_range(0, 99) < 80) ? node_tab[$urandom_range(0, 3)] : node_t'($urandom);
      case ($urandom_range(0, 15))
        0:       opc = OPC_STATUS1;
        1:       opc = OPC_MOTION;
        2:       opc = OPC_TORQUE;
        3:       opc = OPC_SPEED;
        4:       opc = OPC_POS_A3;
        5:       opc = OPC_POS_A4;
        6:       opc = OPC_POS_A5;
        7:       opc = OPC_POS_A6;
        8:       opc = OPC_PHASE;
        9:       opc = OPC_ANGLE;
        10:      opc = OPC_MULTI;
        11:      opc = OPC_ENCODER;
        12:      opc = OPC_GAINS;
        13:      opc = OPC_ACCEL;
        default: opc = 8'($urandom);
      endcase
      d[7:0] = opc;
      // push some frames into the echo tests and the zero error byte
      case ($urandom_range(0, 7))
        0:       d[15:8] = 8'd0;
        1:       d[15:8] = 8'd1;
        2:       d[63:48] = 16'h0000;
        3:       d[63:56] = 8'h00;
        default: ;
      endcase
      send_beat(OP_DECODE, {5'($urandom), node}, d, 2'($urandom), 4'($urandom));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty node table after reset: every frame is from an unknown node
    send_beat(OP_DECODE, 11'h000, {56'h01_0203_0405_0607, OPC_STATUS1}, 2'd0, FLD_TEMP);
    send_beat(OP_DECODE, 11'h7FF, {56'hFF_FFFF_FFFF_FFFF, OPC_MOTION}, 2'd3, FLD_ACCEL);
    send_beat(OP_READ, 11'h000, 64'h0, 2'd3, FLD_GAINS);
    settle();

    node_tab[0] = 6'd0;
    node_tab[1] = 6'd63;
    node_tab[2] = 6'd21;
    node_tab[3] = 6'd42;
    load_table(3'd4);

    send_beat(OP_DECODE, 11'h7FF, {56'h00_1122_3344_5566, OPC_STATUS1}, 2'd0, FLD_TEMP);
    send_beat(OP_DECODE, 11'h000, {56'hFF_FFFF_FFFF_FFFF, OPC_STATUS1}, 2'd3, FLD_UNUSED);
    send_beat(OP_DECODE, 11'h7FF, {56'h12_3456_789A_BC00, OPC_MOTION}, 2'd1, FLD_POS);
    send_beat(OP_DECODE, 11'h7FF, {56'hFF_FFFF_FFFF_FFFF, OPC_MOTION}, 2'd2, FLD_SPEED);
    send_beat(OP_DECODE, 11'h040, {56'h01_0203_0405_0607, OPC_TORQUE}, 2'd0, FLD_TEMP);
    send_beat(OP_DECODE, 11'h7FF, {56'h11_2233_4455_6601, OPC_SPEED}, 2'd1, FLD_VOLT);
    send_beat(OP_DECODE, 11'h7FF, {56'hA0_B0C0_D0E0_F080, OPC_POS_A3}, 2'd1, FLD_ERR);
    send_beat(OP_DECODE, 11'h7FF, {56'h0F_1E2D_3C4B_5A69, OPC_POS_A4}, 2'd1, FLD_TORQUE);
    send_beat(OP_DECODE, 11'h7FF, {56'h77_6655_4433_2201, OPC_POS_A5}, 2'd0, FLD_RAW);
    send_beat(OP_DECODE, 11'h7FF, {56'h77_6655_4433_2200, OPC_POS_A5}, 2'd0, FLD_RAW);
    send_beat(OP_DECODE, 11'h7FF, {56'h98_7654_3210_FE02, OPC_POS_A6}, 2'd0, FLD_OFFSET);
    send_beat(OP_DECODE, 11'h7FF, {56'h00_00AB_CDEF_1234, OPC_PHASE}, 2'd2, FLD_PHASE_A);
    send_beat(OP_DECODE, 11'h7FF, {56'h80_00AB_CDEF_1234, OPC_PHASE}, 2'd2, FLD_PHASE_B);
    send_beat(OP_DECODE, 11'h7FF, {56'hCA_FE12_3456_789A, OPC_ANGLE}, 2'd3, FLD_PHASE_C);
    send_beat(OP_DECODE, 11'h7FF, {56'hFF_FFFF_FFFF_FFFF, OPC_MULTI}, 2'd3, FLD_MULTI);
    send_beat(OP_DECODE, 11'h7FF, {56'h13_5724_68AC_E0BD, OPC_ENCODER}, 2'd1, FLD_RAW);
    send_beat(OP_DECODE, 11'h7FF, {56'hFE_DCBA_9876_5432, OPC_GAINS}, 2'd1, FLD_GAINS);
    send_beat(OP_DECODE, 11'h7FF, {56'h89_ABCD_EF01_2345, OPC_ACCEL}, 2'd1, FLD_ACCEL);
    send_beat(OP_DECODE, 11'h7FF, {56'h01_0203_0405_0607, OPC_NONE_LO}, 2'd0, FLD_TEMP);
    send_beat(OP_DECODE, 11'h015, {56'h01_0203_0405_0607, OPC_NONE_HI}, 2'd0, FLD_TEMP);
    send_beat(OP_DECODE, 11'h287, {56'h01_0203_0405_0607, OPC_STATUS1}, 2'd0, FLD_TEMP);
    send_beat(OP_READ, 11'h7FF, 64'hFFFF_FFFF_FFFF_FFFF, 2'd1, FLD_MULTI);
    send_beat(OP_READ, 11'h000, 64'h0, 2'd1, FLD_PHASE_C);
    send_beat(OP_READ, 11'h000, 64'h0, 2'd1, FLD_UNUSED);
    send_beat(OP_READ, 11'h000, 64'h0, 2'd2, FLD_TEMP);

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      for (int i = 0; i < 4; i++) node_tab[i] = node_t'($urandom);
      case (ph)
        0: begin
          node_tab[0] = 6'd63;
          node_tab[1] = 6'd0;
          load_table(3'd4);
        end
        1: load_table(3'd1);
        // count above the slot total, and a beat stretch with no gaps
        2: begin
          load_table(3'd7);
          no_gaps = 1'b1;
        end
        // duplicate node: the lower slot wins
        3: begin
          no_gaps = 1'b0;
          node_tab[1] = node_tab[0];
          load_table(3'd2);
          write_reg(CFG_SPARE, 6'($urandom));
        end
        4: load_table(3'd0);
        default: load_table(3'd5);
      endcase
      repeat ((ph == 4) ? 100 : 280) random_beat();
    end

    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
